// ----- design/ioc_pkg.sv -----
// Shared types and constants of the IPv4 option area checker.
`timescale 1ns / 1ps
`default_nettype none

package ioc_pkg;

  localparam logic [5:0] MAX_AREA_BYTES = 6'd40;

  localparam logic [7:0] OPT_EOL   = 8'd0;
  localparam logic [7:0] OPT_NOP   = 8'd1;
  localparam logic [7:0] OPT_ALERT = 8'd148;

  localparam logic [7:0] OPT_MIN_LEN   = 8'd2;
  localparam logic [7:0] ALERT_OPT_LEN = 8'd4;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_OK   = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_BODY    = 3'd2,
    PH_PAD     = 3'd3,
    PH_SWALLOW = 3'd4
  } phase_e;

  typedef struct packed {
    logic end_seen;
    logic pad_bad;
    logic fault;
    logic alert;
  } flags_t;

endpackage

`default_nettype wire

// ----- design/ipv4_options_checker_core.sv -----
// Top level of the IPv4 option area checker: byte walk and result register.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   option_byte_i, area_length_i
//   out      output     out_valid_o / out_ready_i verdict_o ... alert_value_o
//
// One option byte is taken per cycle while in_ready_o is high; the walk state updates in the same edge.
// A header's result is registered on the edge that takes its last byte (or its
// only word when the area length is zero) and is shown from the cycle after that edge.
// A waiting result stalls input only while out_ready_i is low.
// Reset clears the walk state and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_options_checker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  option_byte_i,
  input  wire logic [5:0]  area_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       verdict_o,
  output logic [5:0]       area_bytes_o,
  output logic [5:0]       option_count_o,
  output logic [5:0]       noop_count_o,
  output logic             saw_end_marker_o,
  output logic             bad_padding_o,
  output logic             fault_valid_o,
  output logic [5:0]       fault_offset_o,
  output logic             alert_present_o,
  output logic [15:0]      alert_value_o
);

  ioc_pkg::phase_e phase_q, phase_d;
  logic [5:0]      pos_q, pos_d;
  logic [5:0]      len_q, len_d;
  logic [5:0]      start_q, start_d;
  logic [5:0]      body_q, body_d;
  logic            in_alert_q, in_alert_d;
  logic [15:0]     shift_q, shift_d;
  logic [5:0]      opt_cnt_q, opt_cnt_d;
  logic [5:0]      nop_cnt_q, nop_cnt_d;
  ioc_pkg::flags_t flags_q, flags_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      verdict_q, verdict_d;
  logic [5:0]      area_bytes_q, area_bytes_d;
  logic [5:0]      option_count_q, option_count_d;
  logic [5:0]      noop_count_q, noop_count_d;
  logic            end_q, end_d;
  logic            pad_q, pad_d;
  logic            fault_q, fault_d;
  logic [5:0]      offset_q, offset_d;
  logic            alert_q, alert_d;
  logic [15:0]     alert_value_q, alert_value_d;

  logic            accept;
  logic            emit;
  logic [5:0]      len_cur;
  logic [5:0]      left;
  logic [6:0]      pos_next;
  logic            last_byte;
  logic            zero_hdr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    len_d      = len_q;
    start_d    = start_q;
    body_d     = body_q;
    in_alert_d = in_alert_q;
    shift_d    = shift_q;
    opt_cnt_d  = opt_cnt_q;
    nop_cnt_d  = nop_cnt_q;
    flags_d    = flags_q;
    zero_hdr   = 1'b0;
    len_cur    = len_q;

    if (pos_q == 6'd0) begin
      len_cur = (area_length_i > ioc_pkg::MAX_AREA_BYTES) ? ioc_pkg::MAX_AREA_BYTES
                                                         : area_length_i;
      zero_hdr = (len_cur == 6'd0);
    end
    len_d     = len_cur;
    left      = len_cur - start_q;
    pos_next  = {1'b0, pos_q} + 7'd1;
    last_byte = pos_next >= {1'b0, len_cur};
    pos_d     = pos_next[5:0];

    unique case (phase_q)
      ioc_pkg::PH_TYPE: begin
        if (option_byte_i == ioc_pkg::OPT_EOL) begin
          opt_cnt_d        = opt_cnt_q + 6'd1;
          flags_d.end_seen = 1'b1;
          phase_d          = ioc_pkg::PH_PAD;
        end else if (option_byte_i == ioc_pkg::OPT_NOP) begin
          opt_cnt_d = opt_cnt_q + 6'd1;
          nop_cnt_d = nop_cnt_q + 6'd1;
        end else if (last_byte) begin
          flags_d.fault = 1'b1;
          start_d       = pos_q;
          phase_d       = ioc_pkg::PH_SWALLOW;
        end else begin
          start_d    = pos_q;
          in_alert_d = (option_byte_i == ioc_pkg::OPT_ALERT);
          phase_d    = ioc_pkg::PH_LEN;
        end
      end
      ioc_pkg::PH_LEN: begin
        if (option_byte_i < ioc_pkg::OPT_MIN_LEN || option_byte_i > {2'b00, left}) begin
          flags_d.fault = 1'b1;
          phase_d       = ioc_pkg::PH_SWALLOW;
        end else begin
          opt_cnt_d = opt_cnt_q + 6'd1;
          if (in_alert_q && option_byte_i != ioc_pkg::ALERT_OPT_LEN) begin
            flags_d.fault = 1'b1;
            phase_d       = ioc_pkg::PH_SWALLOW;
          end else begin
            body_d  = option_byte_i[5:0] - 6'd2;
            phase_d = (body_d != 6'd0) ? ioc_pkg::PH_BODY : ioc_pkg::PH_TYPE;
          end
        end
      end
      ioc_pkg::PH_BODY: begin
        if (in_alert_q) begin
          shift_d = {shift_q[7:0], option_byte_i};
        end
        if (body_q != 6'd0) begin
          body_d = body_q - 6'd1;
        end
        if (body_d == 6'd0) begin
          if (in_alert_q) begin
            flags_d.alert = 1'b1;
          end
          phase_d = ioc_pkg::PH_TYPE;
        end
      end
      ioc_pkg::PH_PAD: begin
        if (option_byte_i != 8'd0) begin
          flags_d.pad_bad = 1'b1;
          flags_d.fault   = 1'b1;
          start_d         = pos_q;
          phase_d         = ioc_pkg::PH_SWALLOW;
        end
      end
      ioc_pkg::PH_SWALLOW: begin
      end
      default: begin
        phase_d = ioc_pkg::PH_TYPE;
      end
    endcase

    emit = zero_hdr || last_byte;

    if (zero_hdr) begin
      verdict_d      = ioc_pkg::VERDICT_NONE;
      area_bytes_d   = 6'd0;
      option_count_d = 6'd0;
      noop_count_d   = 6'd0;
      end_d          = 1'b0;
      pad_d          = 1'b0;
      fault_d        = 1'b0;
      offset_d       = 6'd0;
      alert_d        = 1'b0;
      alert_value_d  = 16'd0;
    end else begin
      verdict_d      = flags_d.fault ? ioc_pkg::VERDICT_BAD : ioc_pkg::VERDICT_OK;
      area_bytes_d   = len_cur;
      option_count_d = opt_cnt_d;
      noop_count_d   = nop_cnt_d;
      end_d          = flags_d.end_seen;
      pad_d          = flags_d.pad_bad;
      fault_d        = flags_d.fault;
      offset_d       = flags_d.fault ? start_d : 6'd0;
      alert_d        = flags_d.alert;
      alert_value_d  = flags_d.alert ? shift_d : 16'd0;
    end

    if (emit) begin
      phase_d    = ioc_pkg::PH_TYPE;
      pos_d      = 6'd0;
      len_d      = 6'd0;
      start_d    = 6'd0;
      body_d     = 6'd0;
      in_alert_d = 1'b0;
      shift_d    = 16'd0;
      opt_cnt_d  = 6'd0;
      nop_cnt_d  = 6'd0;
      flags_d    = '0;
    end

    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ioc_pkg::PH_TYPE;
      pos_q       <= 6'd0;
      len_q       <= 6'd0;
      start_q     <= 6'd0;
      body_q      <= 6'd0;
      in_alert_q  <= 1'b0;
      shift_q     <= 16'd0;
      opt_cnt_q   <= 6'd0;
      nop_cnt_q   <= 6'd0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        len_q      <= len_d;
        start_q    <= start_d;
        body_q     <= body_d;
        in_alert_q <= in_alert_d;
        shift_q    <= shift_d;
        opt_cnt_q  <= opt_cnt_d;
        nop_cnt_q  <= nop_cnt_d;
        flags_q    <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      verdict_q      <= verdict_d;
      area_bytes_q   <= area_bytes_d;
      option_count_q <= option_count_d;
      noop_count_q   <= noop_count_d;
      end_q          <= end_d;
      pad_q          <= pad_d;
      fault_q        <= fault_d;
      offset_q       <= offset_d;
      alert_q        <= alert_d;
      alert_value_q  <= alert_value_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign area_bytes_o     = area_bytes_q;
  assign option_count_o   = option_count_q;
  assign noop_count_o     = noop_count_q;
  assign saw_end_marker_o = end_q;
  assign bad_padding_o    = pad_q;
  assign fault_valid_o    = fault_q;
  assign fault_offset_o   = offset_q;
  assign alert_present_o  = alert_q;
  assign alert_value_o    = alert_value_q;

endmodule

`default_nettype wire

// ----- design/ioc_checker.sv -----
// Port-level assertions for the IPv4 option area checker, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ioc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  verdict_i,
  input wire logic [5:0]  area_bytes_i,
  input wire logic [5:0]  option_count_i,
  input wire logic [5:0]  noop_count_i,
  input wire logic        bad_padding_i,
  input wire logic        saw_end_marker_i,
  input wire logic        fault_valid_i,
  input wire logic [5:0]  fault_offset_i,
  input wire logic        alert_present_i,
  input wire logic [15:0] alert_value_i
);

  // A stalled result word keeps its valid, its verdict and its area length.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i)
      && $stable(area_bytes_i))
    else $error("stalled result word changed");

  // An empty option area reports nothing else.
  a_empty_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i == ioc_pkg::VERDICT_NONE |->
      area_bytes_i == 6'd0 && option_count_i == 6'd0 && !fault_valid_i
      && !alert_present_i)
    else $error("empty area result carries data");

  // A fault location lies inside the area and matches a malformed verdict.
  a_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fault_valid_i |->
      verdict_i == ioc_pkg::VERDICT_BAD && fault_offset_i < area_bytes_i)
    else $error("fault offset inconsistent");

  // Bad padding implies an end marker, counts stay within the area, and no alert means a zero alert value.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i != ioc_pkg::VERDICT_NONE |->
      area_bytes_i != 6'd0 && area_bytes_i <= ioc_pkg::MAX_AREA_BYTES
      && noop_count_i <= option_count_i && option_count_i <= area_bytes_i
      && (!bad_padding_i || saw_end_marker_i)
      && (alert_present_i || alert_value_i == 16'd0))
    else $error("result counts or flags inconsistent");

endmodule

bind ipv4_options_checker_core ioc_checker u_ioc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .verdict_i        (verdict_o),
  .area_bytes_i     (area_bytes_o),
  .option_count_i   (option_count_o),
  .noop_count_i     (noop_count_o),
  .bad_padding_i    (bad_padding_o),
  .saw_end_marker_i (saw_end_marker_o),
  .fault_valid_i    (fault_valid_o),
  .fault_offset_i   (fault_offset_o),
  .alert_present_i  (alert_present_o),
  .alert_value_i    (alert_value_o)
);

`default_nettype wire
